[hw/rtl/seven_segment_display_frame_gen_defines.svh]
// Assertion macros shared by the display frame generator RTL.
`ifndef SEVEN_SEGMENT_DISPLAY_FRAME_GEN_DEFINES_SVH
`define SEVEN_SEGMENT_DISPLAY_FRAME_GEN_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SSD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[hw/rtl/ssd_pkg.sv]
// Shared types, constants and lookup functions of the display frame generator.
package ssd_pkg;

  // Request modes
  typedef enum logic [1:0] {
    MODE_NUM_AUTO  = 2'd0,
    MODE_NUM_FIXED = 2'd1,
    MODE_TIME      = 2'd2
  } mode_e;

  // Command bytes
  localparam logic [7:0] CMD_AUTO_ADDR   = 8'h40;
  localparam logic [7:0] CMD_FIXED_ADDR  = 8'h44;
  localparam logic [7:0] TIME_START_ADDR = 8'hC0;
  localparam logic [7:0] CTRL_RESET      = 8'h8A;

  // Frame lengths in bytes and the byte counter width
  localparam int AUTO_LEN  = 7;
  localparam int FIXED_LEN = 10;
  localparam int IDX_W     = $clog2(FIXED_LEN);

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Reciprocals for the decimal split: q = (x * RECIP) >> SHIFT
  localparam logic [14:0] RECIP_1000 = 15'd16778;
  localparam int          SHIFT_1000 = 24;
  localparam logic [5:0]  RECIP_100  = 6'd41;
  localparam int          SHIFT_100  = 12;
  localparam logic [6:0]  RECIP_10   = 7'd103;
  localparam int          SHIFT_10   = 10;

  // One frame job handed from front to back
  typedef struct packed {
    logic            fixed;  // fixed addressing frame
    logic [7:0]      addr;   // first address command
    logic [3:0][7:0] seg;    // seg[3] leftmost .. seg[0] units, colon included
  } entry_t;

  // Digit to segment pattern, blank above 9
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'b00111111;
      4'd1:    s = 8'b00000110;
      4'd2:    s = 8'b01011011;
      4'd3:    s = 8'b01001111;
      4'd4:    s = 8'b01100110;
      4'd5:    s = 8'b01101101;
      4'd6:    s = 8'b01111101;
      4'd7:    s = 8'b00000111;
      4'd8:    s = 8'b01111111;
      4'd9:    s = 8'b01101111;
      default: s = 8'b00000000;
    endcase
    return s;
  endfunction

  // q * 1000 for q up to 16
  function automatic logic [13:0] times1000(input logic [4:0] q);
    logic [13:0] p;
    case (q)
      5'd0:    p = 14'd0;
      5'd1:    p = 14'd1000;
      5'd2:    p = 14'd2000;
      5'd3:    p = 14'd3000;
      5'd4:    p = 14'd4000;
      5'd5:    p = 14'd5000;
      5'd6:    p = 14'd6000;
      5'd7:    p = 14'd7000;
      5'd8:    p = 14'd8000;
      5'd9:    p = 14'd9000;
      5'd10:   p = 14'd10000;
      5'd11:   p = 14'd11000;
      5'd12:   p = 14'd12000;
      5'd13:   p = 14'd13000;
      5'd14:   p = 14'd14000;
      5'd15:   p = 14'd15000;
      5'd16:   p = 14'd16000;
      default: p = 14'd0;
    endcase
    return p;
  endfunction

  // q * 100 for q up to 9
  function automatic logic [9:0] times100(input logic [3:0] q);
    logic [9:0] p;
    case (q)
      4'd0:    p = 10'd0;
      4'd1:    p = 10'd100;
      4'd2:    p = 10'd200;
      4'd3:    p = 10'd300;
      4'd4:    p = 10'd400;
      4'd5:    p = 10'd500;
      4'd6:    p = 10'd600;
      4'd7:    p = 10'd700;
      4'd8:    p = 10'd800;
      4'd9:    p = 10'd900;
      default: p = 10'd0;
    endcase
    return p;
  endfunction

  // q * 10 for q up to 9
  function automatic logic [6:0] times10(input logic [3:0] q);
    logic [6:0] p;
    case (q)
      4'd0:    p = 7'd0;
      4'd1:    p = 7'd10;
      4'd2:    p = 7'd20;
      4'd3:    p = 7'd30;
      4'd4:    p = 7'd40;
      4'd5:    p = 7'd50;
      4'd6:    p = 7'd60;
      4'd7:    p = 7'd70;
      4'd8:    p = 7'd80;
      4'd9:    p = 7'd90;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/ssd_front.sv]
// Front end: accepts requests, runs change detection and colon phase, splits digits.
module ssd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           address_i,
  input  logic [13:0]          number_i,
  input  logic                 colon_blink_i,
  input  logic [3:0]           time_units_i,
  input  logic [3:0]           time_tens_i,
  input  logic [3:0]           time_hundreds_i,
  input  logic [3:0]           time_thousands_i,
  output logic                 push_o,
  output ssd_pkg::entry_t      entry_o,
  input  logic                 full_i
);

  // Request attributes carried along the split pipeline
  typedef struct packed {
    logic            fixed;
    logic            is_time;
    logic            colon;
    logic [7:0]      addr;
    logic [3:0][3:0] tdig;  // time digits, [3] leftmost
  } ctl_t;

  logic        rdy1, rdy2, rdy3, acc;
  logic        emit;
  ctl_t        ctl_new;

  // Kept display state
  logic        num_phase_q, num_phase_d;
  logic [13:0] num_last_q, num_last_d;
  logic        time_phase_q, time_phase_d;
  logic [3:0]  time_last_q, time_last_d;

  // Pipeline stages
  logic        s1_v_q, s2_v_q, s3_v_q;
  ctl_t        s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [13:0] s1_num_q;
  logic [9:0]  s2_r1_q;
  logic [3:0]  s2_d3_q;
  logic [6:0]  s3_r2_q;
  logic [3:0]  s3_d3_q, s3_d2_q;

  // Split arithmetic
  logic [28:0] prod1;
  logic [4:0]  q1;
  logic [13:0] r1_full;
  logic [3:0]  d3;
  logic [15:0] prod2;
  logic [3:0]  q2;
  logic [9:0]  r2_full;
  logic [13:0] prod3;
  logic [3:0]  q3;
  logic [6:0]  r3_full;
  logic [3:0]  d1, d0;
  logic [3:0][3:0] digs;

  // Elastic stage handshake
  assign rdy3       = !s3_v_q || !full_i;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_stall_o = !rdy1;
  assign acc        = in_valid_i && rdy1;
  assign push_o     = s3_v_q && !full_i;

  // Classify the request and work out the next kept state
  always_comb begin
    emit           = 1'b0;
    num_phase_d    = num_phase_q;
    num_last_d     = num_last_q;
    time_phase_d   = time_phase_q;
    time_last_d    = time_last_q;
    ctl_new.fixed  = 1'b0;
    ctl_new.is_time = 1'b0;
    ctl_new.colon  = 1'b0;
    ctl_new.addr   = address_i;
    ctl_new.tdig   = {time_thousands_i, time_hundreds_i, time_tens_i, time_units_i};
    case (ssd_pkg::mode_e'(mode_i))
      ssd_pkg::MODE_NUM_AUTO: begin
        if (number_i != num_last_q) begin
          emit          = 1'b1;
          num_last_d    = number_i;
          num_phase_d   = num_phase_q ^ colon_blink_i;
          ctl_new.colon = num_phase_d;
        end
      end
      ssd_pkg::MODE_NUM_FIXED: begin
        emit          = 1'b1;
        ctl_new.fixed = 1'b1;
      end
      ssd_pkg::MODE_TIME: begin
        ctl_new.is_time = 1'b1;
        ctl_new.addr    = ssd_pkg::TIME_START_ADDR;
        if (time_units_i != time_last_q) begin
          emit          = 1'b1;
          time_last_d   = time_units_i;
          time_phase_d  = time_phase_q ^ colon_blink_i;
          ctl_new.colon = time_phase_d;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Kept state and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_phase_q  <= 1'b0;
      num_last_q   <= '0;
      time_phase_q <= 1'b0;
      time_last_q  <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
    end else begin
      if (acc) begin
        num_phase_q  <= num_phase_d;
        num_last_q   <= num_last_d;
        time_phase_q <= time_phase_d;
        time_last_q  <= time_last_d;
      end
      if (rdy1) s1_v_q <= acc && emit;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
    end
  end

  // Thousands: reciprocal multiply, then remainder and digit fold
  assign prod1   = 29'(s1_num_q) * 29'(ssd_pkg::RECIP_1000);
  assign q1      = prod1[ssd_pkg::SHIFT_1000 +: 5];
  assign r1_full = s1_num_q - ssd_pkg::times1000(q1);
  assign d3      = (q1 >= 5'd10) ? 4'(q1 - 5'd10) : q1[3:0];

  // Hundreds
  assign prod2   = 16'(s2_r1_q) * 16'(ssd_pkg::RECIP_100);
  assign q2      = prod2[ssd_pkg::SHIFT_100 +: 4];
  assign r2_full = s2_r1_q - ssd_pkg::times100(q2);

  // Tens and units
  assign prod3   = 14'(s3_r2_q) * 14'(ssd_pkg::RECIP_10);
  assign q3      = prod3[ssd_pkg::SHIFT_10 +: 4];
  assign r3_full = s3_r2_q - ssd_pkg::times10(q3);
  assign d1      = q3;
  assign d0      = r3_full[3:0];

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_ctl_q <= ctl_new;
      s1_num_q <= number_i;
    end
    if (rdy2) begin
      s2_ctl_q <= s1_ctl_q;
      s2_r1_q  <= r1_full[9:0];
      s2_d3_q  <= d3;
    end
    if (rdy3) begin
      s3_ctl_q <= s2_ctl_q;
      s3_r2_q  <= r2_full[6:0];
      s3_d3_q  <= s2_d3_q;
      s3_d2_q  <= q2;
    end
  end

  // Segment mapping; colon goes on the second digit from the left
  assign digs = s3_ctl_q.is_time ? s3_ctl_q.tdig : {s3_d3_q, s3_d2_q, d1, d0};

  always_comb begin
    entry_o.fixed  = s3_ctl_q.fixed;
    entry_o.addr   = s3_ctl_q.addr;
    entry_o.seg[3] = ssd_pkg::seg_of(digs[3]);
    entry_o.seg[2] = ssd_pkg::seg_of(digs[2]) | {s3_ctl_q.colon, 7'b0000000};
    entry_o.seg[1] = ssd_pkg::seg_of(digs[1]);
    entry_o.seg[0] = ssd_pkg::seg_of(digs[0]);
  end

endmodule

[hw/rtl/ssd_fifo.sv]
// Short job queue between the front end and the byte sequencer.
`include "seven_segment_display_frame_gen_defines.svh"

module ssd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ssd_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ssd_pkg::entry_t data_o
);

  localparam logic [ssd_pkg::PTR_W-1:0] PTR_LAST = ssd_pkg::PTR_W'(ssd_pkg::FIFO_DEPTH - 1);
  localparam logic [ssd_pkg::CNT_W-1:0] CNT_FULL = ssd_pkg::CNT_W'(ssd_pkg::FIFO_DEPTH);

  ssd_pkg::entry_t              mem_q [ssd_pkg::FIFO_DEPTH];
  logic [ssd_pkg::PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [ssd_pkg::CNT_W-1:0]    count_q;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  `SSD_NEVER(a_fifo_overflow, push_i && full_o, "push into full job queue")
  `SSD_NEVER(a_fifo_underflow, pop_i && !valid_o, "pop from empty job queue")
  `SSD_ASSERT(a_fifo_ptrs, (count_q == '0 || count_q == CNT_FULL) |-> (wr_ptr_q == rd_ptr_q), "queue pointers disagree with fill level")

endmodule

[hw/rtl/ssd_back.sv]
// Back end: walks one job through its frame bytes and drives the output register.
`include "seven_segment_display_frame_gen_defines.svh"

module ssd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            display_control_we_i,
  input  logic [7:0]      display_control_i,
  input  logic            job_valid_i,
  input  ssd_pkg::entry_t job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      frame_byte_o,
  output logic            start_before_o,
  output logic            stop_after_o,
  output logic            last_byte_o
);

  logic [7:0]              ctrl_q;
  logic                    busy_q;
  logic [ssd_pkg::IDX_W-1:0] idx_q, last_idx;
  ssd_pkg::entry_t         cur_q;
  logic                    out_free, issue, fin;

  logic       out_valid_q;
  logic [7:0] byte_q, byte_n;
  logic       st_q, st_n, sp_q, sp_n, last_q;

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= ssd_pkg::CTRL_RESET;
    end else if (display_control_we_i) begin
      ctrl_q <= display_control_i;
    end
  end

  // Sequencing: one byte per cycle whenever the output register frees up
  assign last_idx = cur_q.fixed ? ssd_pkg::IDX_W'(ssd_pkg::FIXED_LEN - 1)
                                : ssd_pkg::IDX_W'(ssd_pkg::AUTO_LEN - 1);
  assign out_free = !out_valid_q || !out_stall_i;
  assign issue    = busy_q && out_free;
  assign fin      = issue && (idx_q == last_idx);
  assign pop_o    = job_valid_i && (!busy_q || fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o)    busy_q <= 1'b1;
      else if (fin) busy_q <= 1'b0;
      if (pop_o)      idx_q <= '0;
      else if (issue) idx_q <= idx_q + 1'b1;
      if (out_free) out_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= job_i;
  end

  // Byte and framing flags at the current position
  always_comb begin
    byte_n = ctrl_q;
    st_n   = 1'b1;
    sp_n   = 1'b1;
    if (cur_q.fixed) begin
      case (idx_q)
        4'd0: begin byte_n = ssd_pkg::CMD_FIXED_ADDR;           end
        4'd1: begin byte_n = 8'(cur_q.addr + 8'd3); sp_n = 1'b0; end
        4'd2: begin byte_n = cur_q.seg[0];          st_n = 1'b0; end
        4'd3: begin byte_n = 8'(cur_q.addr + 8'd2); sp_n = 1'b0; end
        4'd4: begin byte_n = cur_q.seg[1];          st_n = 1'b0; end
        4'd5: begin byte_n = 8'(cur_q.addr + 8'd1); sp_n = 1'b0; end
        4'd6: begin byte_n = cur_q.seg[2];          st_n = 1'b0; end
        4'd7: begin byte_n = cur_q.addr;            sp_n = 1'b0; end
        4'd8: begin byte_n = cur_q.seg[3];          st_n = 1'b0; end
        default: begin byte_n = ctrl_q; end
      endcase
    end else begin
      case (idx_q)
        4'd0: begin byte_n = ssd_pkg::CMD_AUTO_ADDR;                  end
        4'd1: begin byte_n = cur_q.addr;   sp_n = 1'b0;               end
        4'd2: begin byte_n = cur_q.seg[3]; st_n = 1'b0; sp_n = 1'b0; end
        4'd3: begin byte_n = cur_q.seg[2]; st_n = 1'b0; sp_n = 1'b0; end
        4'd4: begin byte_n = cur_q.seg[1]; st_n = 1'b0; sp_n = 1'b0; end
        4'd5: begin byte_n = cur_q.seg[0]; st_n = 1'b0;               end
        default: begin byte_n = ctrl_q; end
      endcase
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      byte_q <= byte_n;
      st_q   <= st_n;
      sp_q   <= sp_n;
      last_q <= (idx_q == last_idx);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = byte_q;
  assign start_before_o = st_q;
  assign stop_after_o   = sp_q;
  assign last_byte_o    = last_q;

  `SSD_ASSERT(a_idx_range, busy_q |-> (idx_q <= last_idx), "byte counter ran past frame end")
  `SSD_ASSERT(a_last_is_ctrl, (out_valid_o && last_byte_o) |-> (start_before_o && stop_after_o && frame_byte_o == ctrl_q), "final byte is not a framed control command")

endmodule

[hw/rtl/seven_segment_display_frame_gen.sv]
// Top level of the four-digit seven-segment display frame generator.
// Each accepted request becomes a run of framed command and data bytes, one result
// transaction per byte: 7 bytes for number auto-address and time requests, 10 bytes for
// number fixed-address requests, none for an unchanged value or an unused mode. The
// front end takes a request every cycle it is not stalled and splits the number into
// digits in a pipeline; a 2-entry job queue sits in front of the byte sequencer, which
// drives one byte per cycle while the output is not stalled. The user must write the
// display_control register only while the block is idle; the block does not enforce it.
module seven_segment_display_frame_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        display_control_we_i,
  input  logic [7:0]  display_control_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  address_i,
  input  logic [13:0] number_i,
  input  logic        colon_blink_i,
  input  logic [3:0]  time_units_i,
  input  logic [3:0]  time_tens_i,
  input  logic [3:0]  time_hundreds_i,
  input  logic [3:0]  time_thousands_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        start_before_o,
  output logic        stop_after_o,
  output logic        last_byte_o
);

  logic            push, full, pop, job_valid;
  ssd_pkg::entry_t push_entry, job;

  // Request intake and digit split
  ssd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .address_i        (address_i),
    .number_i         (number_i),
    .colon_blink_i    (colon_blink_i),
    .time_units_i     (time_units_i),
    .time_tens_i      (time_tens_i),
    .time_hundreds_i  (time_hundreds_i),
    .time_thousands_i (time_thousands_i),
    .push_o           (push),
    .entry_o          (push_entry),
    .full_i           (full)
  );

  // Job queue
  ssd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job)
  );

  // Byte sequencer
  ssd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .display_control_we_i (display_control_we_i),
    .display_control_i    (display_control_i),
    .job_valid_i          (job_valid),
    .job_i                (job),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .frame_byte_o         (frame_byte_o),
    .start_before_o       (start_before_o),
    .stop_after_o         (stop_after_o),
    .last_byte_o          (last_byte_o)
  );

endmodule

[tb/seven_segment_display_frame_gen_tb.sv]
// Self-checking testbench for the seven-segment display frame generator.
module seven_segment_display_frame_gen_tb;

  // Request field bundle, mode kept as raw bits so the unused code can be driven
  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  address;
    logic [13:0] number;
    logic        colon_blink;
    logic [3:0]  units;
    logic [3:0]  tens;
    logic [3:0]  hundreds;
    logic [3:0]  thousands;
  } request_t;

  // One framed byte as it leaves the block
  typedef struct {
    logic [7:0] data;
    logic       start_before;
    logic       stop_after;
    logic       last_byte;
  } frame_byte_t;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [7:0] SEG_BLANK   = 8'h00;
  localparam logic [7:0] COLON_BIT   = 8'h80;
  localparam logic [7:0] SEG_PATTERN [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        display_control_we_i;
  logic [7:0]  display_control_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  address_i;
  logic [13:0] number_i;
  logic        colon_blink_i;
  logic [3:0]  time_units_i;
  logic [3:0]  time_tens_i;
  logic [3:0]  time_hundreds_i;
  logic [3:0]  time_thousands_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  frame_byte_o;
  logic        start_before_o;
  logic        stop_after_o;
  logic        last_byte_o;

  // Predictor state and expected byte stream
  logic [7:0]  ctrl_byte;
  logic        number_colon;
  logic [13:0] shown_number;
  logic        time_colon;
  logic [3:0]  shown_units;
  frame_byte_t pending_bytes [$];

  // Sender and receiver pacing
  int  burst_left;
  int  max_gap;
  int  stall_pct;
  bit  offering;
  bit  hold_off_req;
  int  fail_count;
  int  cycle_count;

  seven_segment_display_frame_gen dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .display_control_we_i (display_control_we_i),
    .display_control_i    (display_control_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .mode_i               (mode_i),
    .address_i            (address_i),
    .number_i             (number_i),
    .colon_blink_i        (colon_blink_i),
    .time_units_i         (time_units_i),
    .time_tens_i          (time_tens_i),
    .time_hundreds_i      (time_hundreds_i),
    .time_thousands_i     (time_thousands_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .frame_byte_o         (frame_byte_o),
    .start_before_o       (start_before_o),
    .stop_after_o         (stop_after_o),
    .last_byte_o          (last_byte_o)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] segment_of(input logic [3:0] d);
    return (d < 4'd10) ? SEG_PATTERN[d] : SEG_BLANK;
  endfunction

  // Decimal split, leftmost digit first, each digit taken mod 10
  function automatic logic [0:3][7:0] number_segments(input logic [13:0] n);
    logic [0:3][7:0] s;
    int unsigned v;
    v = n;
    s[0] = SEG_PATTERN[(v / 1000) % 10];
    s[1] = SEG_PATTERN[(v / 100) % 10];
    s[2] = SEG_PATTERN[(v / 10) % 10];
    s[3] = SEG_PATTERN[v % 10];
    return s;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic st, input logic sp,
                                    input logic last);
    pending_bytes.push_back('{data: b, start_before: st, stop_after: sp, last_byte: last});
  endfunction

  // Auto-increment frame: command, address plus four digits, control
  function automatic void push_auto_frame(input logic [7:0] addr,
                                          input logic [0:3][7:0] seg);
    push_byte(ssd_pkg::CMD_AUTO_ADDR, 1'b1, 1'b1, 1'b0);
    push_byte(addr, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) push_byte(seg[i], 1'b0, i == 3, 1'b0);
    push_byte(ctrl_byte, 1'b1, 1'b1, 1'b1);
  endfunction

  // Returns the number of bytes the request produces
  function automatic int predict_frame(input request_t r);
    logic [0:3][7:0] seg;
    case (r.mode)
      ssd_pkg::MODE_NUM_AUTO: begin
        if (r.number == shown_number) return 0;
        seg = number_segments(r.number);
        if (r.colon_blink) number_colon = ~number_colon;
        if (number_colon) seg[1] = seg[1] | COLON_BIT;
        shown_number = r.number;
        push_auto_frame(r.address, seg);
        return ssd_pkg::AUTO_LEN;
      end
      ssd_pkg::MODE_NUM_FIXED: begin
        seg = number_segments(r.number);
        push_byte(ssd_pkg::CMD_FIXED_ADDR, 1'b1, 1'b1, 1'b0);
        // units digit first, address counts down from address+3 with wrap
        for (int i = 0; i < 4; i++) begin
          push_byte(r.address + 8'(3 - i), 1'b1, 1'b0, 1'b0);
          push_byte(seg[3 - i], 1'b0, 1'b1, 1'b0);
        end
        push_byte(ctrl_byte, 1'b1, 1'b1, 1'b1);
        return ssd_pkg::FIXED_LEN;
      end
      ssd_pkg::MODE_TIME: begin
        if (r.units == shown_units) return 0;
        seg[0] = segment_of(r.thousands);
        seg[1] = segment_of(r.hundreds);
        seg[2] = segment_of(r.tens);
        seg[3] = segment_of(r.units);
        if (r.colon_blink) time_colon = ~time_colon;
        if (time_colon) seg[1] = seg[1] | COLON_BIT;
        shown_units = r.units;
        push_auto_frame(ssd_pkg::TIME_START_ADDR, seg);
        return ssd_pkg::AUTO_LEN;
      end
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: checks each output transaction, drives stall
  // ---------------------------------------------------------------------------

  initial begin
    frame_byte_t exp_b;
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected byte %02h", frame_byte_o);
          fail_count++;
        end else begin
          exp_b = pending_bytes.pop_front();
          if (frame_byte_o !== exp_b.data) begin
            $error("frame_byte: expected %02h, actual %02h", exp_b.data, frame_byte_o);
            fail_count++;
          end
          if (start_before_o !== exp_b.start_before) begin
            $error("start_before: expected %0b, actual %0b", exp_b.start_before,
                   start_before_o);
            fail_count++;
          end
          if (stop_after_o !== exp_b.stop_after) begin
            $error("stop_after: expected %0b, actual %0b", exp_b.stop_after, stop_after_o);
            fail_count++;
          end
          if (last_byte_o !== exp_b.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", exp_b.last_byte, last_byte_o);
            fail_count++;
          end
        end
      end
      // long hold-off takes priority over the random pattern
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------------

  // Offers one request in bursts with random gaps; returns bytes it produces
  task automatic send_request(input request_t r, output int nbytes);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (max_gap > 0) ? $urandom_range(1, max_gap) : 0;
      if (gap > 0) begin
        if (offering) in_valid_i <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    mode_i           <= r.mode;
    address_i        <= r.address;
    number_i         <= r.number;
    colon_blink_i    <= r.colon_blink;
    time_units_i     <= r.units;
    time_tens_i      <= r.tens;
    time_hundreds_i  <= r.hundreds;
    time_thousands_i <= r.thousands;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    nbytes = predict_frame(r);
  endtask

  // Stops offering and waits until every expected byte has come out
  task automatic wait_idle();
    if (offering) in_valid_i <= 1'b0;
    offering = 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_display_control(input logic [7:0] v);
    display_control_we_i <= 1'b1;
    display_control_i    <= v;
    @(posedge clk_i);
    display_control_we_i <= 1'b0;
    ctrl_byte = v;
    @(posedge clk_i);
  endtask

  function automatic request_t make_request(input logic [1:0] m, input logic [7:0] a,
                                            input logic [13:0] n, input logic c,
                                            input logic [3:0] t0, input logic [3:0] t1,
                                            input logic [3:0] t2, input logic [3:0] t3);
    request_t r;
    r.mode = m; r.address = a; r.number = n; r.colon_blink = c;
    r.units = t0; r.tens = t1; r.hundreds = t2; r.thousands = t3;
    return r;
  endfunction

  function automatic logic [3:0] random_time_digit();
    return ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                        : 4'($urandom_range(10, 15));
  endfunction

  // Random request, weighted toward ones that produce a frame
  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 36)      r.mode = ssd_pkg::MODE_NUM_AUTO;
    else if (pick < 60) r.mode = ssd_pkg::MODE_NUM_FIXED;
    else if (pick < 95) r.mode = ssd_pkg::MODE_TIME;
    else                r.mode = MODE_UNUSED;
    r.address     = 8'($urandom);
    r.colon_blink = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10)      r.number = shown_number;
    else if (pick < 75) r.number = 14'($urandom_range(0, 9999));
    else                r.number = 14'($urandom);
    r.units     = ($urandom_range(0, 99) < 10) ? shown_units : random_time_digit();
    r.tens      = random_time_digit();
    r.hundreds  = random_time_digit();
    r.thousands = random_time_digit();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Values equal to the reset state produce nothing
  task automatic test_reset_state();
    int n;
    send_request(make_request(ssd_pkg::MODE_NUM_AUTO, 8'hC0, 14'd0, 1'b1,
                              '0, '0, '0, '0), n);
    send_request(make_request(ssd_pkg::MODE_TIME, 8'h00, 14'd0, 1'b1,
                              4'd0, 4'd3, 4'd2, 4'd1), n);
    wait_idle();
  endtask

  task automatic test_number_auto();
    int n;
    send_request(make_request(ssd_pkg::MODE_NUM_AUTO, 8'hFF, 14'd9999, 1'b1,
                              '0, '0, '0, '0), n);
    // unchanged value: no frame, colon phase kept
    send_request(make_request(ssd_pkg::MODE_NUM_AUTO, 8'h00, 14'd9999, 1'b1,
                              '0, '0, '0, '0), n);
    // above 9999: digits wrap mod 10
    send_request(make_request(ssd_pkg::MODE_NUM_AUTO, 8'h00, 14'h3FFF, 1'b0,
                              '0, '0, '0, '0), n);
    send_request(make_request(ssd_pkg::MODE_NUM_AUTO, 8'hC0, 14'd0, 1'b1,
                              '0, '0, '0, '0), n);
    send_request(make_request(ssd_pkg::MODE_NUM_AUTO, 8'hC0, 14'd1234, 1'b1,
                              '0, '0, '0, '0), n);
    wait_idle();
  endtask

  // Fixed addressing, address wrap at the top
  task automatic test_number_fixed();
    int n;
    send_request(make_request(ssd_pkg::MODE_NUM_FIXED, 8'hFE, 14'd1234, 1'b1,
                              '0, '0, '0, '0), n);
    send_request(make_request(ssd_pkg::MODE_NUM_FIXED, 8'h00, 14'd0, 1'b0,
                              '0, '0, '0, '0), n);
    send_request(make_request(ssd_pkg::MODE_NUM_FIXED, 8'hFF, 14'h3FFF, 1'b1,
                              '0, '0, '0, '0), n);
    send_request(make_request(ssd_pkg::MODE_NUM_FIXED, 8'hFD, 14'd9999, 1'b0,
                              '0, '0, '0, '0), n);
    wait_idle();
  endtask

  task automatic test_time_digits();
    int n;
    send_request(make_request(ssd_pkg::MODE_TIME, 8'h00, 14'd0, 1'b1,
                              4'd5, 4'd9, 4'd9, 4'd9), n);
    send_request(make_request(ssd_pkg::MODE_TIME, 8'hFF, 14'd0, 1'b1,
                              4'd5, 4'd1, 4'd2, 4'd3), n);
    // digits above 9 show blank
    send_request(make_request(ssd_pkg::MODE_TIME, 8'h00, 14'd0, 1'b1,
                              4'd15, 4'd10, 4'd12, 4'd15), n);
    send_request(make_request(ssd_pkg::MODE_TIME, 8'h00, 14'd0, 1'b0,
                              4'd0, 4'd0, 4'd0, 4'd0), n);
    send_request(make_request(ssd_pkg::MODE_TIME, 8'h00, 14'd0, 1'b1,
                              4'd9, 4'd5, 4'd9, 4'd2), n);
    wait_idle();
  endtask

  // Unused mode code produces nothing and leaves state alone
  task automatic test_unused_mode();
    int n;
    send_request(make_request(MODE_UNUSED, 8'hFF, 14'h3FFF, 1'b1, 4'd15, 4'd15, 4'd15,
                              4'd15), n);
    send_request(make_request(MODE_UNUSED, 8'h00, 14'd0, 1'b0, '0, '0, '0, '0), n);
    send_request(make_request(ssd_pkg::MODE_NUM_FIXED, 8'h10, 14'd42, 1'b0,
                              '0, '0, '0, '0), n);
    wait_idle();
  endtask

  // Random traffic until the requested number of frames has been produced
  task automatic test_random_traffic(input int frames, input int gap, input int pct,
                                     input bit mid_pause);
    int n;
    int done;
    done = 0;
    max_gap = gap;
    stall_pct = pct;
    while (done < frames) begin
      send_request(random_request(), n);
      if (n > 0) done++;
      // sender pauses until the output has drained
      if (mid_pause && done == frames / 2 && n > 0) wait_idle();
    end
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    int n;
    max_gap = 0;
    burst_left = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_request(make_request(ssd_pkg::MODE_NUM_FIXED, 8'($urandom), 14'($urandom),
                                1'b0, '0, '0, '0, '0), n);
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    ctrl_byte    = ssd_pkg::CTRL_RESET;
    number_colon = 1'b0;
    shown_number = '0;
    time_colon   = 1'b0;
    shown_units  = '0;
    burst_left   = 0;
    max_gap      = 3;
    stall_pct    = 25;
    offering     = 1'b0;
    hold_off_req = 1'b0;
    fail_count   = 0;
    cycle_count  = 0;

    rst_ni               <= 1'b0;
    display_control_we_i <= 1'b0;
    display_control_i    <= '0;
    in_valid_i           <= 1'b0;
    mode_i               <= '0;
    address_i            <= '0;
    number_i             <= '0;
    colon_blink_i        <= 1'b0;
    time_units_i         <= '0;
    time_tens_i          <= '0;
    time_hundreds_i      <= '0;
    time_thousands_i     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part runs with the reset control byte
    test_reset_state();
    test_number_auto();
    test_number_fixed();
    test_time_digits();
    test_unused_mode();

    write_display_control(8'h00);
    test_random_traffic(25, 5, 30, 1'b0);
    test_backpressure();

    write_display_control(8'hFF);
    test_random_traffic(25, 0, 0, 1'b1);

    write_display_control(8'($urandom));
    test_random_traffic(25, 10, 60, 1'b0);

    write_display_control(ssd_pkg::CTRL_RESET);
    test_random_traffic(10, 2, 10, 1'b0);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
